### rtl/empi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modular inverse and power package
// Widths, status codes, command codes and the queued job record shared by
// the front and back parts of the unit.
// ----------------------------------------------------------------------------
package empi_pkg;

   localparam int Width = 16;

   localparam logic CMD_INVERSE = 1'b0;
   localparam logic CMD_POWER   = 1'b1;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NOT_COPRIME = 2'd1,
      ST_ZERO_MOD    = 2'd2
   } status_type;

   typedef struct packed {
      logic             cmd;
      logic [Width-1:0] base;
      logic [Width-1:0] exponent;
      logic [Width-1:0] modulus;
   } job_type;

   typedef struct packed {
      logic [Width-1:0] value;
      status_type       status;
   } result_type;

   localparam int JobQueueDepth = 2;

endpackage
`default_nettype wire

### rtl/euler_modular_power_inverse_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Euler modular inverse and power unit
// Channel   Direction  Handshake     Payload
// req_      in         push / full   cmd, base, exponent, modulus
// rsp_      out        empty / pop   value, status
// Each item with a non-zero modulus runs on the shared bit-serial divider,
// used for gcd steps, trial divisions up to the square root of the modulus
// and each modular multiply. Reset is synchronous and clears the queue and
// sequencer. Inputs queue up to two items while the back part works; a
// result waits in its register until popped.
// ----------------------------------------------------------------------------
module euler_modular_power_inverse_top
   import empi_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic               req_cmd,
   input  wire logic [Width-1:0]   req_base,
   input  wire logic [Width-1:0]   req_exponent,
   input  wire logic [Width-1:0]   req_modulus,
   output logic                    empty,
   input  wire logic               pop,
   output logic [Width-1:0]        rsp_value,
   output logic [1:0]              rsp_status
);

   job_type    job_in, job_q;
   logic       job_valid, job_take, res_valid;
   result_type res;

   assign job_in = '{cmd: req_cmd, base: req_base, exponent: req_exponent,
                     modulus: req_modulus};

   empi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .job_in    (job_in),
      .job_valid (job_valid),
      .job_take  (job_take),
      .job_out   (job_q)
   );

   empi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_take  (job_take),
      .job       (job_q),
      .res_valid (res_valid),
      .res_take  (pop),
      .res       (res)
   );

   assign empty      = !res_valid;
   assign rsp_value  = res.value;
   assign rsp_status = res.status;

`ifndef NO_ASSERTIONS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status != ST_OK |-> rsp_value == '0)
      else $error("error item carries a non-zero value");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_status != 2'd3)
      else $error("undefined status code");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid)
      else $error("back part took from an empty queue");
`endif

endmodule
`default_nettype wire

### rtl/empi_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modular inverse and power: shared divider
// Restoring divider, one quotient bit a cycle, for a dividend of up to twice
// the operand width. Results hold until the next start.
// ----------------------------------------------------------------------------
module empi_divider
   import empi_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [2*Width-1:0]   dividend,
   input  wire logic [Width-1:0]     divisor,
   output logic                      done,
   output logic [2*Width-1:0]        quotient,
   output logic [Width-1:0]          remainder
);

   localparam int CountBits = $clog2(2 * Width + 1);

   logic [CountBits-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [2*Width-1:0]   quo_ff, quo_in;
   logic [Width:0]       rem_ff, rem_in;
   logic [Width-1:0]     div_ff, div_in;
   logic [Width:0]       trial;
   logic [Width:0]       shifted;

   always_comb begin
      shifted  = {rem_ff[Width-1:0], quo_ff[2*Width-1]};
      trial    = shifted - {1'b0, div_ff};
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = CountBits'(2 * Width);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[Width]) begin
            rem_in = trial;
            quo_in = {quo_ff[2*Width-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[2*Width-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CountBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[Width-1:0];

endmodule
`default_nettype wire

### rtl/empi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modular inverse and power: front part
// Accepts items and keeps them in a short queue for the back part.
// ----------------------------------------------------------------------------
module empi_front
   import empi_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire job_type    job_in,
   output logic            job_valid,
   input  wire logic       job_take,
   output job_type         job_out
);

   localparam int PtrBits = $clog2(JobQueueDepth);

   job_type              mem_ff [JobQueueDepth];
   logic [PtrBits-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrBits:0]     cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full      = (cnt_ff == (PtrBits+1)'(JobQueueDepth));
   assign job_valid = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = job_take && job_valid;
   assign job_out   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrBits+1)'(do_push) - (PtrBits+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= job_in;
      end
   end

endmodule
`default_nettype wire

### rtl/empi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modular inverse and power: back part
// Sequencer for the gcd, the trial-division totient and square-and-multiply,
// all on one shared divider, with a one-entry result register.
// ----------------------------------------------------------------------------
module empi_back
   import empi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   output logic             job_take,
   input  wire job_type     job,
   output logic             res_valid,
   input  wire logic        res_take,
   output result_type       res
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_GCD    = 11'b00000000010,
      S_GCDW   = 11'b00000000100,
      S_TCHK   = 11'b00000001000,
      S_TDIVW  = 11'b00000010000,
      S_ACCW   = 11'b00000100000,
      S_EXPW   = 11'b00001000000,
      S_MULT   = 11'b00010000000,
      S_MULTW  = 11'b00100000000,
      S_SQRW   = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   state_type          state_ff, state_in;
   logic               cmd_ff, cmd_in;
   logic [Width-1:0]   exp_ff, exp_in;
   logic [Width-1:0]   n_ff, n_in;
   logic [Width-1:0]   x_ff, x_in;
   logic [Width-1:0]   y_ff, y_in;
   logic [Width-1:0]   acc_ff, acc_in;
   logic [Width-1:0]   rest_ff, rest_in;
   logic [Width-1:0]   p_ff, p_in;
   logic               hit_ff, hit_in;
   logic [Width-1:0]   e_ff, e_in;
   logic [Width-1:0]   r_ff, r_in;
   logic [Width-1:0]   a_ff, a_in;
   logic [2*Width-1:0] prod_ff, prod_in;
   logic [2*Width+1:0] psq;
   logic               rv_ff, rv_in;
   result_type         res_ff, res_in;
   result_type         fin_ff, fin_in;

   logic               div_start;
   logic [2*Width-1:0] div_a;
   logic [Width-1:0]   div_b;
   logic               div_done;
   logic [2*Width-1:0] div_q;
   logic [Width-1:0]   div_r;

   empi_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign psq = {1'b0, p_ff, 1'b0} * {1'b0, p_ff, 1'b0} >> 2;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      exp_in    = exp_ff;
      n_in      = n_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      rest_in   = rest_ff;
      p_in      = p_ff;
      hit_in    = hit_ff;
      e_in      = e_ff;
      r_in      = r_ff;
      a_in      = a_ff;
      prod_in   = prod_ff;
      rv_in     = rv_ff;
      res_in    = res_ff;
      fin_in    = fin_ff;
      job_take  = 1'b0;
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      if (res_take && rv_ff) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               cmd_in   = job.cmd;
               exp_in   = job.exponent;
               n_in     = job.modulus;
               x_in     = job.base;
               y_in     = job.modulus;
               a_in     = job.base;
               if (job.modulus == '0) begin
                  fin_in   = '{value: '0, status: ST_ZERO_MOD};
                  state_in = S_DONE;
               end else begin
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            if (y_ff == '0) begin
               if (x_ff != Width'(1)) begin
                  fin_in   = '{value: '0, status: ST_NOT_COPRIME};
                  state_in = S_DONE;
               end else begin
                  acc_in   = n_ff;
                  rest_in  = n_ff;
                  p_in     = Width'(2);
                  state_in = S_TCHK;
               end
            end else begin
               div_start = 1'b1;
               div_a     = (2*Width)'(x_ff);
               div_b     = y_ff;
               state_in  = S_GCDW;
            end
         end
         S_GCDW: begin
            if (div_done) begin
               x_in     = y_ff;
               y_in     = div_r;
               state_in = S_GCD;
            end
         end
         S_TCHK: begin
            if (psq[2*Width-1:0] <= (2*Width)'(rest_ff) && psq[2*Width+1:2*Width] == '0) begin
               hit_in    = 1'b0;
               div_start = 1'b1;
               div_a     = (2*Width)'(rest_ff);
               div_b     = p_ff;
               state_in  = S_TDIVW;
            end else if (rest_ff > Width'(1)) begin
               p_in      = rest_ff;
               rest_in   = Width'(1);
               div_start = 1'b1;
               div_a     = (2*Width)'(acc_ff);
               div_b     = rest_ff;
               state_in  = S_ACCW;
            end else begin
               div_start = 1'b1;
               div_a     = (2*Width)'(exp_ff);
               div_b     = acc_ff;
               state_in  = S_EXPW;
            end
         end
         S_TDIVW: begin
            if (div_done) begin
               if (div_r == '0) begin
                  hit_in    = 1'b1;
                  rest_in   = div_q[Width-1:0];
                  div_start = 1'b1;
                  div_a     = (2*Width)'(div_q[Width-1:0]);
                  div_b     = p_ff;
               end else if (hit_ff) begin
                  div_start = 1'b1;
                  div_a     = (2*Width)'(acc_ff);
                  div_b     = p_ff;
                  state_in  = S_ACCW;
               end else begin
                  p_in     = p_ff + 1'b1;
                  state_in = S_TCHK;
               end
            end
         end
         S_ACCW: begin
            if (div_done) begin
               acc_in   = acc_ff - div_q[Width-1:0];
               p_in     = p_ff + 1'b1;
               state_in = S_TCHK;
            end
         end
         S_EXPW: begin
            if (div_done) begin
               e_in = (cmd_ff == CMD_INVERSE) ? acc_ff - 1'b1 : div_r;
               r_in = Width'(1);
               if (n_ff == Width'(1)) begin
                  fin_in   = '{value: Width'(1), status: ST_OK};
                  state_in = S_DONE;
               end else begin
                  div_start = 1'b1;
                  div_a     = (2*Width)'(a_ff);
                  div_b     = n_ff;
                  state_in  = S_SQRW;
                  e_in      = (cmd_ff == CMD_INVERSE) ? acc_ff - 1'b1 : div_r;
                  hit_in    = 1'b0;
               end
            end
         end
         S_MULT: begin
            if (e_ff == '0) begin
               fin_in   = '{value: r_ff, status: ST_OK};
               state_in = S_DONE;
            end else if (e_ff[0] && !hit_ff) begin
               div_start = 1'b1;
               div_a     = prod_ff;
               div_b     = n_ff;
               state_in  = S_MULTW;
            end else begin
               div_start = 1'b1;
               div_a     = a_ff * a_ff;
               div_b     = n_ff;
               e_in      = e_ff >> 1;
               hit_in    = 1'b1;
               state_in  = S_SQRW;
            end
         end
         S_MULTW: begin
            if (div_done) begin
               r_in     = div_r;
               hit_in   = 1'b1;
               prod_in  = '0;
               state_in = S_MULT;
            end
         end
         S_SQRW: begin
            if (div_done) begin
               a_in     = div_r;
               hit_in   = 1'b0;
               prod_in  = r_ff * div_r;
               state_in = S_MULT;
            end
         end
         S_DONE: begin
            if (!rv_ff || res_take) begin
               rv_in    = 1'b1;
               res_in   = fin_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_MULTW && div_done) begin
         prod_in = r_ff * a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      cmd_ff  <= cmd_in;
      exp_ff  <= exp_in;
      n_ff    <= n_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      rest_ff <= rest_in;
      p_ff    <= p_in;
      hit_ff  <= hit_in;
      e_ff    <= e_in;
      r_ff    <= r_in;
      a_ff    <= a_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      fin_ff  <= fin_in;
   end

   assign res_valid = rv_ff;
   assign res       = res_ff;

endmodule
`default_nettype wire

### tb/euler_modular_power_inverse_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Euler modular inverse and power unit testbench
// Drives inverse and power requests through the push/full queue interface,
// predicts each answer with an independent gcd, totient and square-and-
// multiply calculation, and checks every popped result in order. Sender and
// receiver idle at random in three phases, and one long receiver hold-off
// fills the input queue.
// ----------------------------------------------------------------------------
module euler_modular_power_inverse_top_tb;
   import empi_pkg::*;

   class residue_scoreboard;
      result_type pending[$];
      int         mismatches;
      int         checked;

      function automatic logic [31:0] gcd32(logic [31:0] x, logic [31:0] y);
         logic [31:0] r;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         return x;
      endfunction

      function automatic logic [31:0] phi32(logic [31:0] n);
         logic [31:0] acc;
         logic [31:0] rest;
         logic [31:0] p;
         acc = n;
         rest = n;
         for (p = 2; p * p <= rest; p++) begin
            if (rest % p == 0) begin
               while (rest % p == 0) rest = rest / p;
               acc = acc - acc / p;
            end
         end
         if (rest > 1) acc = acc - acc / rest;
         return acc;
      endfunction

      function automatic logic [63:0] powmod(logic [63:0] a, logic [63:0] e,
                                             logic [63:0] m);
         logic [63:0] r;
         r = 1;
         a = a % m;
         while (e > 0) begin
            if (e[0]) r = (r * a) % m;
            e = e >> 1;
            a = (a * a) % m;
         end
         return r;
      endfunction

      function void note_request(logic c, logic [Width-1:0] a, logic [Width-1:0] b,
                                 logic [Width-1:0] n);
         result_type r;
         logic [31:0] ph;
         logic [31:0] e;
         r.value = '0;
         if (n == 0) r.status = ST_ZERO_MOD;
         else if (gcd32(a, n) != 1) r.status = ST_NOT_COPRIME;
         else begin
            ph = phi32(n);
            e = (c == CMD_INVERSE) ? ph - 1 : b % ph;
            r.value = Width'(powmod(a, e, n));
            r.status = ST_OK;
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [Width-1:0] v, logic [1:0] s);
         result_type x;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result value=%0d status=%0d", v, s);
            return;
         end
         x = pending.pop_front();
         if (x.value !== v || x.status !== s) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                        x.value, x.status, v, s);
         end
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             push = 0;
   logic             pop = 0;
   logic             req_cmd = 0;
   logic [Width-1:0] req_base = 0;
   logic [Width-1:0] req_exponent = 0;
   logic [Width-1:0] req_modulus = 0;
   logic             full;
   logic             empty;
   logic [Width-1:0] rsp_value;
   logic [1:0]       rsp_status;

   residue_scoreboard board;
   int  send_idle = 23;
   int  recv_idle = 86;
   bit  hold_off = 0;
   int  cycles = 0;
   int  sent = 0;

   always #6 clock = ~clock;

   euler_modular_power_inverse_top u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_cmd(req_cmd), .req_base(req_base), .req_exponent(req_exponent),
      .req_modulus(req_modulus), .empty(empty), .pop(pop),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("Timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) board.check_result(rsp_value, rsp_status);
         pop <= !hold_off && ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_item(logic c, logic [Width-1:0] a, logic [Width-1:0] b,
                            logic [Width-1:0] n);
      while ($urandom_range(99) < send_idle) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_cmd <= c;
      req_base <= a;
      req_exponent <= b;
      req_modulus <= n;
      @(posedge clock);
      while (full) @(posedge clock);
      board.note_request(c, a, b, n);
      sent++;
   endtask

   task automatic send_random;
      logic [Width-1:0] n;
      logic [Width-1:0] a;
      case ($urandom_range(9))
         0: n = Width'($urandom);
         1, 2: n = Width'($urandom_range(3));
         default: n = Width'($urandom_range(2000, 2));
      endcase
      a = Width'($urandom);
      if ($urandom_range(3) != 0 && n > 1) begin
         a = Width'($urandom_range(n - 1, 1));
         while (board.gcd32(a, n) != 1) a = Width'($urandom_range(n - 1, 1));
      end
      send_item(1'($urandom_range(1)), a, Width'($urandom), n);
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_item(CMD_INVERSE, 3, 0, 0);
      send_item(CMD_POWER, 16'hFFFF, 16'hFFFF, 0);
      send_item(CMD_INVERSE, 0, 0, 1);
      send_item(CMD_POWER, 16'hFFFF, 16'hFFFF, 1);
      send_item(CMD_INVERSE, 0, 0, 7);
      send_item(CMD_INVERSE, 6, 0, 9);
      send_item(CMD_INVERSE, 3, 0, 7);
      send_item(CMD_POWER, 5, 0, 13);
      send_item(CMD_POWER, 2, 16'hFFFF, 16'hFFFF);
      send_item(CMD_INVERSE, 16'hFFFE, 0, 16'hFFFF);
      send_item(CMD_INVERSE, 2, 0, 16'hFFF1);
      send_item(CMD_POWER, 16'hAAAA, 16'h5555, 16'h5555);
      send_item(CMD_POWER, 16'h5555, 16'hAAAA, 16'hAAAB);
      send_item(CMD_INVERSE, 1, 0, 2);
      send_item(CMD_POWER, 16'hFFFF, 16'h8000, 16'hFFFE);
      for (int i = 0; i < 30; i++) send_random();
      hold_off = 1;
      for (int i = 0; i < 8; i++) send_random();
      hold_off = 0;
      send_idle = 86;
      recv_idle = 23;
      for (int i = 0; i < 30; i++) send_random();
      send_idle = 0;
      recv_idle = 0;
      for (int i = 0; i < 30; i++) send_random();
      push <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d items (both commands, edge moduli, coprime and not), checked %0d.",
               sent, board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // The hold-off stretch, counted in cycles, lets the queue fill and stall push.
   initial begin
      wait (hold_off);
      repeat (40000) @(posedge clock);
      hold_off = 0;
   end

endmodule
